// ----- hw/rtl/isee_pkg.sv -----
// ----------------------------------------------------------------------------
// isee_pkg
// Shared widths, function codes and controller states for the interval
// squared-error engine.
// ----------------------------------------------------------------------------
package isee_pkg;

    // Default point store depth
    localparam int DEPTH       = 4096;

    // Point format: the low SAMPLE_BITS bits of point_value are two's complement
    localparam int POINT_W     = 16;
    localparam int SAMPLE_BITS = 16;

    // Index and interval length widths
    localparam int IDX_W       = 12;
    localparam int LEN_W       = IDX_W + 1;

    // Prefix store widths (kept modulo 2^W; interval differences stay exact)
    localparam int SUM_W       = 29;
    localparam int SQ_W        = 43;

    // Result field widths
    localparam int OUT_SUM_W   = 28;
    localparam int NUM_W       = LEN_W + SQ_W;
    localparam int DIV_CNT_W   = $clog2(SQ_W);

    // Stream widths
    localparam int FUNC_W      = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 120;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_SUM_W - 2 * SQ_W;

    // Function codes carried in the input tuser
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_SQ,
        ST_APP_WR,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_DIFF,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/isee_ram.sv -----
// ----------------------------------------------------------------------------
// isee_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module isee_ram #(
    parameter int WIDTH = isee_pkg::SUM_W,
    parameter int DEPTH = isee_pkg::DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/interval_squared_error_engine.sv -----
// ----------------------------------------------------------------------------
// interval_squared_error_engine
// Sequence: clear and append give no output beat; a query gives one beat, after
//   two reads, difference, products and 43 divider steps when its range is valid.
// Throughput: one item at a time; a query holds off the next beat until its
//   result is loaded. The next beat is taken while a result waits.
// Reset: synchronous, active low; clears the point set and the controller.
//   The prefix RAMs have no reset and are read only after being written.
// ----------------------------------------------------------------------------
module interval_squared_error_engine #(
    parameter int DEPTH = isee_pkg::DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // point_value[15:0], first_index[27:16], last_index[39:28]
    input  logic [isee_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // func[1:0]
    input  logic [isee_pkg::FUNC_W-1:0]     i_s_axis_tuser,

    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // interval_sum[27:0], interval_square_sum[70:28], sq_error[113:71],
    // zero pad[119:114]
    output logic [isee_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // range_error[0]
    output logic [0:0]                      o_m_axis_tuser
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > isee_pkg::IDX_W) ? CNT_W : isee_pkg::IDX_W;

    localparam int POINT_W   = isee_pkg::POINT_W;
    localparam int SMP_W     = isee_pkg::SAMPLE_BITS;
    localparam int IDX_W     = isee_pkg::IDX_W;
    localparam int LEN_W     = isee_pkg::LEN_W;
    localparam int SUM_W     = isee_pkg::SUM_W;
    localparam int SQ_W      = isee_pkg::SQ_W;
    localparam int OSUM_W    = isee_pkg::OUT_SUM_W;
    localparam int NUM_W     = isee_pkg::NUM_W;
    localparam int DCNT_W    = isee_pkg::DIV_CNT_W;

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    isee_pkg::t_state r_state, n_state;

    logic [POINT_W-1:0]         w_point;
    logic [IDX_W-1:0]           w_first;
    logic [IDX_W-1:0]           w_last;
    logic [isee_pkg::FUNC_W-1:0] w_func;
    logic                       w_accept;
    logic                       w_range_bad;
    logic                       w_has_room;

    logic                       w_mem_wr;
    logic                       w_load;

    logic [CNT_W-1:0]           r_count;
    logic [SUM_W-1:0]           r_run_sum;
    logic [SQ_W-1:0]            r_run_sq;
    logic [SUM_W-1:0]           n_run_sum;
    logic [SQ_W-1:0]            n_run_sq;

    logic signed [SMP_W-1:0]    r_sample;
    logic [SMP_W-1:0]           w_mag;
    logic [2*SMP_W-1:0]         r_sq_term;

    logic [IDX_W-1:0]           r_first;
    logic [IDX_W-1:0]           r_last;
    logic [LEN_W-1:0]           r_len;
    logic                       r_err;

    logic [ADDR_W-1:0]          w_rd_addr;
    logic [SUM_W-1:0]           w_rd_sum;
    logic [SQ_W-1:0]            w_rd_sq;
    logic [SUM_W-1:0]           r_hi_sum;
    logic [SQ_W-1:0]            r_hi_sq;
    logic [SUM_W-1:0]           r_sum;
    logic [SQ_W-1:0]            r_sq;

    logic [SUM_W-1:0]           w_abs;
    logic [OSUM_W-1:0]          w_smag;
    logic [NUM_W-1:0]           r_prod_len;
    logic [NUM_W-1:0]           r_prod_sum;
    logic [NUM_W-1:0]           w_num;

    logic [LEN_W-1:0]           r_rem;
    logic [SQ_W-1:0]            r_quo;
    logic [DCNT_W-1:0]          r_div_cnt;
    logic [LEN_W:0]             w_trial;
    logic [LEN_W:0]             w_len_ext;
    logic                       w_ge;

    logic                       r_out_valid;
    logic [OSUM_W-1:0]          r_out_sum;
    logic [SQ_W-1:0]            r_out_sq;
    logic [SQ_W-1:0]            r_out_cost;
    logic                       r_out_err;

    // ------------------------------------------------------------------------
    // Input beat unpack and range check
    // ------------------------------------------------------------------------
    assign w_point  = i_s_axis_tdata[POINT_W-1:0];
    assign w_first  = i_s_axis_tdata[POINT_W +: IDX_W];
    assign w_last   = i_s_axis_tdata[POINT_W + IDX_W +: IDX_W];
    assign w_func   = i_s_axis_tuser;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign w_range_bad = (w_first > w_last) || (CMP_W'(w_last) >= CMP_W'(r_count));
    assign w_has_room  = (r_count < CNT_W'(DEPTH));

    // ------------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isee_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Next state and control
    // ------------------------------------------------------------------------
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_mem_wr        = 1'b0;
        w_load          = 1'b0;
        unique case (r_state)
            isee_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    unique case (w_func)
                        isee_pkg::FUNC_APPEND: begin
                            if (w_has_room) begin
                                n_state = isee_pkg::ST_APP_SQ;
                            end
                        end
                        isee_pkg::FUNC_QUERY: begin
                            n_state = w_range_bad ? isee_pkg::ST_DONE
                                                  : isee_pkg::ST_RD_LAST;
                        end
                        default: begin
                            n_state = isee_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            isee_pkg::ST_APP_SQ: begin
                n_state = isee_pkg::ST_APP_WR;
            end
            isee_pkg::ST_APP_WR: begin
                w_mem_wr = 1'b1;
                n_state  = isee_pkg::ST_IDLE;
            end
            isee_pkg::ST_RD_LAST: begin
                n_state = isee_pkg::ST_RD_FIRST;
            end
            isee_pkg::ST_RD_FIRST: begin
                n_state = isee_pkg::ST_DIFF;
            end
            isee_pkg::ST_DIFF: begin
                n_state = isee_pkg::ST_MUL;
            end
            isee_pkg::ST_MUL: begin
                n_state = isee_pkg::ST_SUB;
            end
            isee_pkg::ST_SUB: begin
                n_state = isee_pkg::ST_DIV;
            end
            isee_pkg::ST_DIV: begin
                if (r_div_cnt == DCNT_W'(SQ_W - 1)) begin
                    n_state = isee_pkg::ST_DONE;
                end
            end
            isee_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = isee_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = isee_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Point count and running sums
    // ------------------------------------------------------------------------
    assign n_run_sum = r_run_sum + SUM_W'(r_sample);
    assign n_run_sq  = r_run_sq + SQ_W'(r_sq_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_run_sum <= '0;
            r_run_sq  <= '0;
        end else if (w_accept && (w_func == isee_pkg::FUNC_CLEAR)) begin
            r_count   <= '0;
            r_run_sum <= '0;
            r_run_sq  <= '0;
        end else if (w_mem_wr) begin
            r_count   <= r_count + CNT_W'(1);
            r_run_sum <= n_run_sum;
            r_run_sq  <= n_run_sq;
        end
    end

    // ------------------------------------------------------------------------
    // Append path: latch sample, square its magnitude
    // ------------------------------------------------------------------------
    assign w_mag = r_sample[SMP_W-1] ? SMP_W'(-r_sample) : SMP_W'(r_sample);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= w_point[SMP_W-1:0];
        end
        if (r_state == isee_pkg::ST_APP_SQ) begin
            r_sq_term <= w_mag * w_mag;
        end
    end

    // ------------------------------------------------------------------------
    // Prefix memories
    // ------------------------------------------------------------------------
    assign w_rd_addr = (r_state == isee_pkg::ST_RD_LAST) ? ADDR_W'(r_last)
                                                         : ADDR_W'(r_first - IDX_W'(1));

    isee_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr),
        .i_wr_addr (ADDR_W'(r_count)),
        .i_wr_data (n_run_sum),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_sum)
    );

    isee_ram #(
        .WIDTH (SQ_W),
        .DEPTH (DEPTH)
    ) u_sq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr),
        .i_wr_addr (ADDR_W'(r_count)),
        .i_wr_data (n_run_sq),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_sq)
    );

    // ------------------------------------------------------------------------
    // Query path: capture range, difference the prefixes, form products
    // ------------------------------------------------------------------------
    assign w_abs  = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign w_smag = w_abs[OSUM_W-1:0];
    assign w_num  = r_prod_len - r_prod_sum;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= w_first;
            r_last  <= w_last;
            r_len   <= LEN_W'(w_last) - LEN_W'(w_first) + LEN_W'(1);
            r_err   <= w_range_bad;
        end
        if (r_state == isee_pkg::ST_RD_FIRST) begin
            r_hi_sum <= w_rd_sum;
            r_hi_sq  <= w_rd_sq;
        end
        // Interval starting at point zero takes the upper prefix as is
        if (r_state == isee_pkg::ST_DIFF) begin
            if (r_first == '0) begin
                r_sum <= r_hi_sum;
                r_sq  <= r_hi_sq;
            end else begin
                r_sum <= r_hi_sum - w_rd_sum;
                r_sq  <= r_hi_sq - w_rd_sq;
            end
        end
        if (r_state == isee_pkg::ST_MUL) begin
            r_prod_len <= r_len * r_sq;
            r_prod_sum <= w_smag * w_smag;
        end
    end

    // ------------------------------------------------------------------------
    // Restoring divider: one quotient bit per cycle. The quotient fits SQ_W
    // bits, so the top of the numerator is already below the length.
    // ------------------------------------------------------------------------
    assign w_trial   = {r_rem, r_quo[SQ_W-1]};
    assign w_len_ext = {1'b0, r_len};
    assign w_ge      = (w_trial >= w_len_ext);

    always_ff @(posedge i_clk) begin
        if (r_state == isee_pkg::ST_SUB) begin
            r_rem     <= w_num[NUM_W-1:SQ_W];
            r_quo     <= w_num[SQ_W-1:0];
            r_div_cnt <= '0;
        end else if (r_state == isee_pkg::ST_DIV) begin
            r_rem     <= w_ge ? LEN_W'(w_trial - w_len_ext) : w_trial[LEN_W-1:0];
            r_quo     <= {r_quo[SQ_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Output register: hold result until the beat is taken
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_err) begin
                r_out_sum  <= '0;
                r_out_sq   <= '0;
                r_out_cost <= '0;
                r_out_err  <= 1'b1;
            end else begin
                r_out_sum  <= r_sum[OSUM_W-1:0];
                r_out_sq   <= r_sq;
                r_out_cost <= r_quo;
                r_out_err  <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{isee_pkg::OUT_PAD_W{1'b0}}, r_out_cost, r_out_sq, r_out_sum};
    assign o_m_axis_tuser  = r_out_err;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("range error beat carries nonzero data");

    a_cost_le_sq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (r_out_cost <= r_out_sq))
        else $error("interval cost exceeds square sum");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isee_pkg::ST_DIV) |-> (r_rem < r_len))
        else $error("divider remainder not below interval length");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_wr |-> (r_count < CNT_W'(DEPTH)))
        else $error("prefix write beyond store depth");

endmodule
